// File: hdl/gde_pkg.sv
// Shared constants and codes for the grid diffusion block.
// Used by the top level, the shared multiplier and the port checker.
package gde_pkg;

   localparam int GRID_WIDTH_DEF  = 64;
   localparam int GRID_HEIGHT_DEF = 64;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;
   localparam int MUL_W       = 32;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_RATE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRAP = 2'd2;

   localparam logic [16:0] ONE_Q16    = 17'h10000;
   localparam logic [16:0] RATE_RESET = 17'h08000;
   localparam logic [16:0] KEEP_RESET = 17'h10000;

   // Reciprocals for exact division of a 32-bit value by three and by five.
   localparam logic [MUL_W-1:0] RECIP3 = 32'hAAAAAAAB;
   localparam logic [MUL_W-1:0] RECIP5 = 32'hCCCCCCCD;

endpackage

// File: hdl/grid_diffuse_evaporate.sv
// Top level of the grid diffusion block: grid memories, sequencer, registers.
// Depends on gde_pkg and gde_mul.
//
// Usage: one request word carries a write, a read or a tick action. Every
// request gives exactly one response word with the level read (zero for
// anything but a read) and the echoed action code.
// Registers are written through the csr_ port; the user must do so only while
// the block is idle, as the block does not enforce it. After reset a clearing
// pass zeroes the level memory, one cell a cycle; req_tready stays low meanwhile.
// A write answers in the cycle after acceptance; a read answers after ST_READ.
// A tick walks the grid twice through the single shared multiplier: first
// each cell's outgoing share (ST_S_RD, ST_S_M1, ST_S_M2, and ST_S_M3 on a
// bounded border), then each cell gathers the shares of its neighbours and
// applies keep and evaporation (ST_G_NB, then ST_G_K1 to ST_G_K4).
// One request is in the block at a time: req_tready is low while an action
// runs and while a response word waits. A stalled receiver simply holds the
// response word and the block waits with it.
module grid_diffuse_evaporate #(
   parameter int GRID_WIDTH  = gde_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = gde_pkg::GRID_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // action[1:0], x_pos[7:2], y_pos[13:8], level_in[45:14], zero pad
   input  logic [gde_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // level_out[31:0], action_done[33:32], zero pad
   output logic [gde_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [gde_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gde_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gde_pkg::*;

   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int XW    = $clog2(GRID_WIDTH);
   localparam int YW    = $clog2(GRID_HEIGHT);
   localparam logic [XW-1:0] XMAX      = XW'(GRID_WIDTH - 1);
   localparam logic [YW-1:0] YMAX      = YW'(GRID_HEIGHT - 1);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [AW-1:0] ROW_LEN   = AW'(GRID_WIDTH);
   localparam logic [3:0]    NB_COUNT  = 4'd8;

   typedef enum logic [11:0] {
      ST_CLEAR = 12'b0000_0000_0001,
      ST_IDLE  = 12'b0000_0000_0010,
      ST_READ  = 12'b0000_0000_0100,
      ST_S_RD  = 12'b0000_0000_1000,
      ST_S_M1  = 12'b0000_0001_0000,
      ST_S_M2  = 12'b0000_0010_0000,
      ST_S_M3  = 12'b0000_0100_0000,
      ST_G_NB  = 12'b0000_1000_0000,
      ST_G_K1  = 12'b0001_0000_0000,
      ST_G_K2  = 12'b0010_0000_0000,
      ST_G_K3  = 12'b0100_0000_0000,
      ST_G_K4  = 12'b1000_0000_0000
   } state_type;

   // Request fields
   logic [1:0]  req_action;
   logic [5:0]  req_x;
   logic [5:0]  req_y;
   logic [31:0] req_level;
   logic        req_inside;
   logic [AW-1:0] req_addr;

   assign req_action = req_tdata[1:0];
   assign req_x      = req_tdata[7:2];
   assign req_y      = req_tdata[13:8];
   assign req_level  = req_tdata[45:14];
   assign req_inside = (32'(req_x) < GRID_WIDTH) && (32'(req_y) < GRID_HEIGHT);
   assign req_addr   = AW'(AW'(req_y) * ROW_LEN) + AW'(req_x);

   // Configuration registers
   logic [16:0] rate_ff, keep_ff;
   logic        wrap_ff;
   logic [16:0] rate_sat, keep_sat, rate_rest;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
         keep_ff <= KEEP_RESET;
         wrap_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RATE: rate_ff <= csr_wdata;
            CSR_KEEP: keep_ff <= csr_wdata;
            CSR_WRAP: wrap_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign rate_sat  = (rate_ff > ONE_Q16) ? ONE_Q16 : rate_ff;
   assign keep_sat  = (keep_ff > ONE_Q16) ? ONE_Q16 : keep_ff;
   assign rate_rest = ONE_Q16 - rate_sat;

   // Sequencer registers
   state_type     state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [3:0]    k_ff, k_in;
   logic          nbv_ff, nbv_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_level_ff, rsp_level_in;
   logic [1:0]    rsp_act_ff, rsp_act_in;
   logic          inside_ff, inside_in;
   logic [31:0]   acc_ff, acc_in;
   logic [31:0]   sum_ff, sum_in;

   // Memories
   logic [31:0]   level_mem [CELLS];
   logic [31:0]   inflow_mem [CELLS];
   logic [31:0]   lv_rd_ff, sh_rd_ff;
   logic          lv_we, sh_we;
   logic [AW-1:0] lv_waddr, lv_raddr, sh_raddr;
   logic [31:0]   lv_wdata, sh_wdata;

   always_ff @(posedge clock) begin
      if (lv_we) begin
         level_mem[lv_waddr] <= lv_wdata;
      end
      lv_rd_ff <= level_mem[lv_raddr];
   end

   always_ff @(posedge clock) begin
      if (sh_we) begin
         inflow_mem[addr_ff] <= sh_wdata;
      end
      sh_rd_ff <= inflow_mem[sh_raddr];
   end

   // Shared multiplier
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [2*MUL_W-1:0] mul_p;
   logic [31:0]        prod_q16;

   gde_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   assign prod_q16 = mul_p[47:16];

   // Neighbour count of the current cell while shares are computed.
   logic edge_x, edge_y, cell_n3, cell_n5, cell_n8;

   assign edge_x  = (x_ff == '0) || (x_ff == XMAX);
   assign edge_y  = (y_ff == '0) || (y_ff == YMAX);
   assign cell_n3 = !wrap_ff && edge_x && edge_y;
   assign cell_n5 = !wrap_ff && (edge_x ^ edge_y);
   assign cell_n8 = !cell_n3 && !cell_n5;

   // Neighbour k of the current cell, numbered row by row around it.
   logic [2:0]    k_low;
   logic          dxm, dxp, dym, dyp, nb_ok;
   logic [XW-1:0] nx;
   logic [YW-1:0] ny;
   logic [AW-1:0] nb_addr;

   assign k_low = k_ff[2:0];
   assign dxm   = (k_low == 3'd0) || (k_low == 3'd3) || (k_low == 3'd5);
   assign dxp   = (k_low == 3'd2) || (k_low == 3'd4) || (k_low == 3'd7);
   assign dym   = (k_low <= 3'd2);
   assign dyp   = (k_low >= 3'd5);

   always_comb begin
      nx    = x_ff;
      ny    = y_ff;
      nb_ok = 1'b1;
      if (dxm) begin
         if (x_ff == '0) begin
            nx    = XMAX;
            nb_ok = nb_ok && wrap_ff;
         end else begin
            nx = x_ff - 1'b1;
         end
      end
      if (dxp) begin
         if (x_ff == XMAX) begin
            nx    = '0;
            nb_ok = nb_ok && wrap_ff;
         end else begin
            nx = x_ff + 1'b1;
         end
      end
      if (dym) begin
         if (y_ff == '0) begin
            ny    = YMAX;
            nb_ok = nb_ok && wrap_ff;
         end else begin
            ny = y_ff - 1'b1;
         end
      end
      if (dyp) begin
         if (y_ff == YMAX) begin
            ny    = '0;
            nb_ok = nb_ok && wrap_ff;
         end else begin
            ny = y_ff + 1'b1;
         end
      end
   end

   assign nb_addr = AW'(AW'(ny) * ROW_LEN) + AW'(nx);

   // Saturating adders
   logic [32:0] acc_sum, kept_sum;
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, sh_rd_ff};
   assign kept_sum = {1'b0, prod_q16} + {1'b0, acc_ff};

   logic last_cell;
   assign last_cell = (addr_ff == LAST_CELL);

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      nbv_in       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_level_in = rsp_level_ff;
      rsp_act_in   = rsp_act_ff;
      inside_in    = inside_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      lv_we        = 1'b0;
      lv_waddr     = addr_ff;
      lv_wdata     = '0;
      lv_raddr     = addr_ff;
      sh_we        = 1'b0;
      sh_wdata     = '0;
      sh_raddr     = nb_addr;
      mul_a        = lv_rd_ff;
      mul_b        = '0;

      case (state_ff)
         ST_CLEAR: begin
            lv_we = 1'b1;
            if (last_cell) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               rsp_act_in   = req_action;
               rsp_level_in = '0;
               case (req_action)
                  ACT_WRITE: begin
                     lv_we        = req_inside;
                     lv_waddr     = req_addr;
                     lv_wdata     = req_level;
                     rsp_valid_in = 1'b1;
                  end
                  ACT_READ: begin
                     lv_raddr  = req_addr;
                     inside_in = req_inside;
                     state_in  = ST_READ;
                  end
                  ACT_TICK: begin
                     addr_in  = '0;
                     x_in     = '0;
                     y_in     = '0;
                     state_in = ST_S_RD;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_level_in = inside_ff ? lv_rd_ff : '0;
            state_in     = ST_IDLE;
         end
         ST_S_RD: begin
            state_in = ST_S_M1;
         end
         ST_S_M1: begin
            mul_b    = MUL_W'(rate_sat);
            state_in = ST_S_M2;
         end
         ST_S_M2, ST_S_M3: begin
            if (state_ff == ST_S_M2 && !cell_n8) begin
               // Divide the scaled level by the neighbour count through a reciprocal.
               mul_a    = prod_q16;
               mul_b    = cell_n5 ? RECIP5 : RECIP3;
               state_in = ST_S_M3;
            end else begin
               sh_we = 1'b1;
               if (state_ff == ST_S_M2) begin
                  sh_wdata = {3'b000, prod_q16[31:3]};
               end else if (cell_n5) begin
                  sh_wdata = {2'b00, mul_p[63:34]};
               end else begin
                  sh_wdata = {1'b0, mul_p[63:33]};
               end
               if (last_cell) begin
                  addr_in  = '0;
                  x_in     = '0;
                  y_in     = '0;
                  k_in     = '0;
                  acc_in   = '0;
                  state_in = ST_G_NB;
               end else begin
                  addr_in  = addr_ff + 1'b1;
                  x_in     = (x_ff == XMAX) ? '0 : x_ff + 1'b1;
                  y_in     = (x_ff == XMAX) ? y_ff + 1'b1 : y_ff;
                  state_in = ST_S_RD;
               end
            end
         end
         ST_G_NB: begin
            if (nbv_ff) begin
               acc_in = acc_sum[32] ? '1 : acc_sum[31:0];
            end
            if (k_ff < NB_COUNT) begin
               nbv_in = nb_ok;
               k_in   = k_ff + 1'b1;
            end else begin
               state_in = ST_G_K1;
            end
         end
         ST_G_K1: begin
            mul_b    = MUL_W'(rate_rest);
            state_in = ST_G_K2;
         end
         ST_G_K2: begin
            sum_in   = kept_sum[32] ? '1 : kept_sum[31:0];
            state_in = ST_G_K3;
         end
         ST_G_K3: begin
            mul_a    = sum_ff;
            mul_b    = MUL_W'(keep_sat);
            state_in = ST_G_K4;
         end
         ST_G_K4: begin
            lv_we    = 1'b1;
            lv_wdata = prod_q16;
            k_in     = '0;
            acc_in   = '0;
            if (last_cell) begin
               addr_in      = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               addr_in  = addr_ff + 1'b1;
               x_in     = (x_ff == XMAX) ? '0 : x_ff + 1'b1;
               y_in     = (x_ff == XMAX) ? y_ff + 1'b1 : y_ff;
               state_in = ST_G_NB;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         k_ff         <= '0;
         nbv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         k_ff         <= k_in;
         nbv_ff       <= nbv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_level_ff <= rsp_level_in;
      rsp_act_ff   <= rsp_act_in;
      inside_ff    <= inside_in;
      acc_ff       <= acc_in;
      sum_ff       <= sum_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_act_ff, rsp_level_ff};

endmodule

// File: hdl/gde_mul.sv
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on gde_pkg for the operand width.
module gde_mul (
   input  logic                          clock,
   input  logic [gde_pkg::MUL_W-1:0]     mul_a,
   input  logic [gde_pkg::MUL_W-1:0]     mul_b,
   output logic [2*gde_pkg::MUL_W-1:0]   mul_p
);
   import gde_pkg::*;

   logic [2*MUL_W-1:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= mul_a * mul_b;
   end

   assign mul_p = p_ff;

endmodule

// File: hdl/gde_checker.sv
// Port checker for the grid diffusion block, bound to the top level.
// Depends on gde_pkg for widths and action codes.
module gde_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [gde_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import gde_pkg::*;

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // Only one word is in the block at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous one is open");

   // Anything but a read reports a zero level.
   a_zero_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] != ACT_READ |-> rsp_tdata[31:0] == 32'd0)
      else $error("non-zero level on a response other than a read");

   // The clearing pass keeps the request side closed after reset.
   a_clear_pass: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("block open straight after reset");

endmodule

bind grid_diffuse_evaporate gde_checker u_gde_checker (.*);
